>>> rtl/uqspd_pkg.sv
// shared types and constants for the url query splitter and percent decoder
package uqspd_pkg;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;

    // one result of the tagged output stream
    typedef struct packed {
        logic       tend;
        logic [1:0] kind;
        logic       has;
        logic [7:0] data;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        res_t [MAX_RES-1:0] ent;
        logic [CNT_W-1:0]   cnt;
    } rec_t;

endpackage

>>> rtl/uqspd_front.sv
// front end: classifies each url byte, runs the escape state and builds its result record
module uqspd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                end_of_url,
    output logic                push,
    output uqspd_pkg::rec_t     rec
);

    typedef enum logic [1:0] {
        SEC_PATH  = 2'd0,
        SEC_KEY   = 2'd1,
        SEC_VALUE = 2'd2
    } section_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX  = 2'd2
    } esc_t;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    section_t   section_reg, section_next;
    esc_t       esc_reg, esc_next;
    logic [7:0] held_reg, held_next;
    logic       started_reg, started_next;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
                return {1'b1, d[3:0]};
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - 8'h37;
                return {1'b1, d[3:0]};
            end else if (c inside {[8'h61:8'h66]}) begin
                d = c - 8'h57;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    function automatic uqspd_pkg::rec_t add(input uqspd_pkg::rec_t r, input logic [7:0] d,
                                            input logic h, input logic [1:0] k,
                                            input logic e);
        uqspd_pkg::rec_t o;
        begin
            o = r;
            o.ent[r.cnt].data = d;
            o.ent[r.cnt].has  = h;
            o.ent[r.cnt].kind = k;
            o.ent[r.cnt].tend = e;
            o.cnt = r.cnt + 3'd1;
            return o;
        end
    endfunction

    // pending escape comes out literally
    function automatic uqspd_pkg::rec_t flush(input uqspd_pkg::rec_t r, input logic [1:0] esc,
                                              input logic [7:0] held, input logic [1:0] k);
        uqspd_pkg::rec_t o;
        begin
            o = r;
            if (esc == ESC_PCT) begin
                o = add(o, CH_PCT, 1'b1, k, 1'b0);
            end else if (esc == ESC_HEX) begin
                o = add(o, CH_PCT, 1'b1, k, 1'b0);
                o = add(o, held, 1'b1, k, 1'b0);
            end
            return o;
        end
    endfunction

    always_comb begin
        uqspd_pkg::rec_t r;
        logic [4:0] hv;
        logic [4:0] hh;
        logic       done;
        r            = '0;
        section_next = section_reg;
        esc_next     = esc_reg;
        held_next    = held_reg;
        started_next = started_reg;
        hv           = hex_val(in_byte);
        hh           = hex_val(held_reg);
        done         = 1'b0;

        if (section_next == SEC_PATH) begin
            if (in_byte == CH_QUERY) begin
                r            = add(r, 8'h00, 1'b0, SEC_PATH, 1'b1);
                section_next = SEC_KEY;
                started_next = 1'b0;
                esc_next     = ESC_NONE;
            end else begin
                r = add(r, in_byte, 1'b1, SEC_PATH, 1'b0);
            end
        end else if (in_byte == CH_AMP) begin
            r        = flush(r, esc_next, held_next, section_next);
            esc_next = ESC_NONE;
            if (section_next == SEC_KEY) begin
                r = add(r, 8'h00, 1'b0, SEC_KEY, 1'b1);
            end
            r            = add(r, 8'h00, 1'b0, SEC_VALUE, 1'b1);
            section_next = SEC_KEY;
            started_next = 1'b0;
        end else if (in_byte == CH_EQ && section_next == SEC_KEY) begin
            r            = flush(r, esc_next, held_next, section_next);
            esc_next     = ESC_NONE;
            r            = add(r, 8'h00, 1'b0, SEC_KEY, 1'b1);
            section_next = SEC_VALUE;
            started_next = 1'b1;
        end else begin
            started_next = 1'b1;
            if (esc_next == ESC_PCT) begin
                if (hv[4]) begin
                    held_next = in_byte;
                    esc_next  = ESC_HEX;
                    done      = 1'b1;
                end else begin
                    r        = flush(r, esc_next, held_next, section_next);
                    esc_next = ESC_NONE;
                end
            end else if (esc_next == ESC_HEX) begin
                if (hv[4]) begin
                    r        = add(r, {hh[3:0], hv[3:0]}, 1'b1, section_next, 1'b0);
                    esc_next = ESC_NONE;
                    done     = 1'b1;
                end else begin
                    r        = flush(r, esc_next, held_next, section_next);
                    esc_next = ESC_NONE;
                end
            end
            if (!done) begin
                if (in_byte == CH_PCT) begin
                    esc_next = ESC_PCT;
                end else if (in_byte == CH_PLUS) begin
                    r = add(r, CH_SPACE, 1'b1, section_next, 1'b0);
                end else begin
                    r = add(r, in_byte, 1'b1, section_next, 1'b0);
                end
            end
        end

        if (end_of_url) begin
            if (section_next == SEC_PATH) begin
                r = add(r, 8'h00, 1'b0, SEC_PATH, 1'b1);
            end else begin
                r = flush(r, esc_next, held_next, section_next);
                if (section_next == SEC_KEY) begin
                    if (started_next) begin
                        r = add(r, 8'h00, 1'b0, SEC_KEY, 1'b1);
                        r = add(r, 8'h00, 1'b0, SEC_VALUE, 1'b1);
                    end
                end else begin
                    r = add(r, 8'h00, 1'b0, SEC_VALUE, 1'b1);
                end
            end
            section_next = SEC_PATH;
            esc_next     = ESC_NONE;
            held_next    = 8'h00;
            started_next = 1'b0;
        end
        rec = r;
    end

    assign push = accept && (rec.cnt != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_reg <= SEC_PATH;
            esc_reg     <= ESC_NONE;
            held_reg    <= 8'h00;
            started_reg <= 1'b0;
        end else if (accept) begin
            section_reg <= section_next;
            esc_reg     <= esc_next;
            held_reg    <= held_next;
            started_reg <= started_next;
        end
    end

endmodule

>>> rtl/uqspd_queue.sv
// short record queue between the front end and the back end
module uqspd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  uqspd_pkg::rec_t wr_rec,
    input  logic            pop,
    output uqspd_pkg::rec_t rd_rec,
    output logic            not_empty,
    output logic            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uqspd_pkg::rec_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign rd_rec    = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/uqspd_back.sv
// back end: walks each record one result per cycle into the output register, while the receiver does not stall
module uqspd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  uqspd_pkg::rec_t q_rec,
    input  logic            q_valid,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [3:0]      m_tuser,
    output logic            m_tlast
);

    uqspd_pkg::rec_t               cur_reg;
    logic                          cur_valid_reg;
    logic [uqspd_pkg::CNT_W-1:0]   idx_reg;
    logic                          out_valid_reg;
    uqspd_pkg::res_t               out_reg;
    logic                          out_last_reg;

    logic load;
    logic is_last;

    assign is_last = (idx_reg == cur_reg.cnt - 3'd1);
    assign load    = cur_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop   = q_valid && (!cur_valid_reg || (load && is_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (load && is_last) begin
                cur_valid_reg <= 1'b0;
            end else if (load) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_rec;
        end
        if (load) begin
            out_reg      <= cur_reg.ent[idx_reg];
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = {out_reg.tend, out_reg.kind, out_reg.has};
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/url_query_splitter_percent_decoder.sv
// top level of the url query splitter and percent decoder
//
// input channel s_: one url byte per transaction in s_tdata, s_tlast on the final byte
// output channel m_: tagged token stream, one result per transaction
//   m_tdata  decoded character (zero on a pure end marker)
//   m_tuser  token flags, m_tlast closes the results of one input byte
// the path passes raw up to the first '?', then '&' splits pairs and the first '='
// splits key from value; key and value bytes are percent decoded and '+' becomes space
// an input byte yields zero to five results; bytes that yield none (a '%' say)
// produce no output transaction at all
// a byte's results go through the record queue, the current record register and the
// output register; throughput: one byte per cycle while each byte yields at most one
// result and the receiver is ready; a byte with several results holds the back end
// longer, and the record queue between front and back absorbs such bursts until it fills, then s_tready drops
// when the receiver stalls the output register holds, the back end waits and the
// queue keeps taking bytes until full
// reset (aresetn low, synchronous) returns to the path section, clears any pending
// escape and empties the queue and output register; the final byte of a url does the
// same to the parser state
module url_query_splitter_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_url
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [0] has_byte, [2:1] token_kind, [3] token_end
    output logic       m_tlast    // last_result
);

    logic            accept;
    logic            push;
    uqspd_pkg::rec_t front_rec;
    uqspd_pkg::rec_t q_rec;
    logic            q_valid;
    logic            q_full;
    logic            q_pop;

    // the front end never stalls on its own, only on a full queue
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    uqspd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .end_of_url (s_tlast),
        .push       (push),
        .rec        (front_rec)
    );

    // records with no results are never queued
    uqspd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_rec    (front_rec),
        .pop       (q_pop),
        .rd_rec    (q_rec),
        .not_empty (q_valid),
        .full      (q_full)
    );

    uqspd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rec    (q_rec),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/uqspd_checker.sv
// port level checks for the url query splitter, bound to the top level
module uqspd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);

    // an end marker never carries a character
    a_end_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> !m_tuser[0])
        else $error("token end with a character");

    // a pure marker has zero data
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("marker with nonzero data");

    // a marker always closes a token
    a_marker_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[3] && m_tuser[2:1] != 2'd3)
        else $error("bad marker tags");

    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output changed under stall");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind url_query_splitter_percent_decoder uqspd_checker u_uqspd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> verif/testbench.sv
// self-checking testbench for the url query splitter and percent decoder
`timescale 1ns / 100ps

module testbench;

    // token kinds as they travel in m_tuser[2:1]
    typedef enum logic [1:0] {
        KIND_PATH  = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_VALUE = 2'd2
    } kind_t;

    // progress through a percent escape
    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_PERCENT = 2'd1,
        ESC_DIGIT   = 2'd2
    } esc_t;

    localparam logic [7:0] CH_PERCENT = "%";
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_SPACE   = " ";
    localparam logic [7:0] CH_QUERY   = "?";
    localparam logic [7:0] CH_AMP     = "&";
    localparam logic [7:0] CH_EQUALS  = "=";

    localparam int RANDOM_BYTES = 480;
    localparam int CALM_BYTES   = 90;   // final stretch with no idling
    localparam int SETTLE       = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        kind_t      kind;
        logic       tend;
        logic       last;
    } tok_t;

    // predicts the token stream and checks the block's results against it
    class token_checker_t;
        kind_t      section;
        esc_t       esc_stage;
        logic [7:0] held_digit;
        logic       seg_open;
        tok_t       tokens_due[$];
        tok_t       step_toks[$];
        int         mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            section    = KIND_PATH;
            esc_stage  = ESC_NONE;
            held_digit = 8'h00;
            seg_open   = 1'b0;
        endfunction

        function int nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            return -1;
        endfunction

        function void push_tok(logic [7:0] c, logic has, kind_t k, logic te);
            tok_t t;
            t.ch   = has ? c : 8'h00;
            t.has  = has;
            t.kind = k;
            t.tend = te;
            t.last = 1'b0;
            step_toks = {step_toks, t};
        endfunction

        // a pending escape comes out literally
        function void flush_escape();
            if (esc_stage == ESC_PERCENT) begin
                push_tok(CH_PERCENT, 1'b1, section, 1'b0);
            end else if (esc_stage == ESC_DIGIT) begin
                push_tok(CH_PERCENT, 1'b1, section, 1'b0);
                push_tok(held_digit, 1'b1, section, 1'b0);
            end
            esc_stage = ESC_NONE;
        endfunction

        function void decode_char(logic [7:0] c);
            int         v;
            logic [3:0] hi;
            v = nibble(c);
            if (esc_stage == ESC_PERCENT) begin
                if (v >= 0) begin
                    held_digit = c;
                    esc_stage  = ESC_DIGIT;
                    return;
                end
                flush_escape();
            end else if (esc_stage == ESC_DIGIT) begin
                if (v >= 0) begin
                    hi = 4'(nibble(held_digit));
                    push_tok({hi, 4'(v)}, 1'b1, section, 1'b0);
                    esc_stage = ESC_NONE;
                    return;
                end
                flush_escape();
            end
            // the offending byte of a bad escape is handled afresh here
            if (c == CH_PERCENT) esc_stage = ESC_PERCENT;
            else if (c == CH_PLUS) push_tok(CH_SPACE, 1'b1, section, 1'b0);
            else push_tok(c, 1'b1, section, 1'b0);
        endfunction

        // one accepted input transaction
        function void note_byte(logic [7:0] c, logic fin);
            if (section == KIND_PATH) begin
                if (c == CH_QUERY) begin
                    push_tok(8'h00, 1'b0, KIND_PATH, 1'b1);
                    section   = KIND_KEY;
                    seg_open  = 1'b0;
                    esc_stage = ESC_NONE;
                end else begin
                    push_tok(c, 1'b1, KIND_PATH, 1'b0);
                end
            end else if (c == CH_AMP) begin
                flush_escape();
                if (section == KIND_KEY) push_tok(8'h00, 1'b0, KIND_KEY, 1'b1);
                push_tok(8'h00, 1'b0, KIND_VALUE, 1'b1);
                section  = KIND_KEY;
                seg_open = 1'b0;
            end else if (c == CH_EQUALS && section == KIND_KEY) begin
                flush_escape();
                push_tok(8'h00, 1'b0, KIND_KEY, 1'b1);
                section  = KIND_VALUE;
                seg_open = 1'b1;
            end else begin
                seg_open = 1'b1;
                decode_char(c);
            end

            if (fin) begin
                if (section == KIND_PATH) begin
                    push_tok(8'h00, 1'b0, KIND_PATH, 1'b1);
                end else begin
                    flush_escape();
                    if (section == KIND_KEY) begin
                        // an empty final segment gives no pair
                        if (seg_open) begin
                            push_tok(8'h00, 1'b0, KIND_KEY, 1'b1);
                            push_tok(8'h00, 1'b0, KIND_VALUE, 1'b1);
                        end
                    end else begin
                        push_tok(8'h00, 1'b0, KIND_VALUE, 1'b1);
                    end
                end
                restart();
            end

            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
            tokens_due = {tokens_due, step_toks};
            step_toks.delete();
        endfunction

        // one accepted output transaction
        function void check_token(tok_t got);
            tok_t want;
            if (tokens_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result data %02h has %0b kind %0d end %0b last %0b",
                             $time, got.ch, got.has, got.kind, got.tend, got.last);
                return;
            end
            want = tokens_due.pop_front();
            if (got.ch !== want.ch || got.has !== want.has || got.kind !== want.kind ||
                got.tend !== want.tend || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected data %02h has %0b kind %0d end %0b last %0b",
                             $time, want.ch, want.has, want.kind, want.tend, want.last);
                    $display("%0t:      got data %02h has %0b kind %0d end %0b last %0b",
                             $time, got.ch, got.has, got.kind, got.tend, got.last);
                end
            end
        endfunction

        function bit busy();
            return tokens_due.size() != 0;
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    token_checker_t board = new();

    bit         gaps_on   = 1'b1;   // sender idles in bursts
    bit         stalls_on = 1'b1;   // receiver stalls in bursts
    int         bytes_sent = 0;
    logic [7:0] url_bytes[$];
    tok_t       seen;

    url_query_splitter_percent_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // inputs only change at rising edges, so what is seen at the falling edge
    // is exactly what the next rising edge will accept
    always @(negedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            seen.ch   = m_tdata;
            seen.has  = m_tuser[0];
            seen.kind = kind_t'(m_tuser[2:1]);
            seen.tend = m_tuser[3];
            seen.last = m_tlast;
            board.check_token(seen);
        end
    end

    // receiver: ready by default, with stall bursts while stalls are enabled
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // append one byte to the url being built
    function void put_char(input logic [7:0] c);
        url_bytes = {url_bytes, c};
    endfunction

    // one input transaction, with an optional idle burst ahead of it
    task send_byte(input logic [7:0] c, input logic fin);
        logic took;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        bytes_sent++;
    endtask

    task send_url();
        foreach (url_bytes[i]) send_byte(url_bytes[i], i == url_bytes.size() - 1);
        url_bytes.delete();
    endtask

    task queue_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    // hold the sender off until every expected result has come out
    task drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.busy()) @(posedge aclk);
    endtask

    function logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function logic [7:0] word_char();
        return pick("abcdefghijklmnopqrstuvwxyz0123456789/._-");
    endfunction

    function logic [7:0] any_hex();
        return pick("0123456789abcdefABCDEF");
    endfunction

    // never a hex digit, often something the parser treats specially
    function logic [7:0] non_hex();
        return pick("gxZ%+&=?./-");
    endfunction

    function logic [7:0] path_char();
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 6) return word_char();
        if (r < 8) return pick("%+=&");
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUERY);
        return c;
    endfunction

    // a key or a value of up to three pieces
    task add_field();
        int r;
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                put_char(word_char());
            end else if (r < 55) begin
                put_char(CH_PERCENT);
                put_char(any_hex());
                put_char(any_hex());
            end else if (r < 63) begin
                put_char(CH_PERCENT);
                put_char(any_hex());
                put_char(non_hex());
            end else if (r < 68) begin
                put_char(CH_PERCENT);
                put_char(non_hex());
            end else if (r < 78) begin
                put_char(CH_PLUS);
            end else if (r < 86) begin
                put_char(8'($urandom_range(0, 255)));
            end else if (r < 93) begin
                put_char(CH_EQUALS);
            end else begin
                put_char(CH_QUERY);
            end
        end
    endtask

    task build_url();
        int pairs;
        url_bytes.delete();
        if ($urandom_range(0, 99) < 15) begin
            // noise: raw bytes with delimiters sprinkled in
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 1) == 0) put_char(8'($urandom_range(0, 255)));
                else put_char(pick("?&=%+"));
            end
        end else begin
            repeat ($urandom_range(0, 4)) put_char(path_char());
            if ($urandom_range(0, 9) != 0) begin
                put_char(CH_QUERY);
                pairs = $urandom_range(0, 4);
                for (int i = 0; i < pairs; i++) begin
                    if (i > 0) put_char(CH_AMP);
                    add_field();
                    if ($urandom_range(0, 99) < 80) begin
                        put_char(CH_EQUALS);
                        add_field();
                    end
                end
                if ($urandom_range(0, 99) < 15) put_char(CH_AMP);
            end
            if (url_bytes.size() == 0) put_char(path_char());
        end
    endtask

    initial begin
        bit drained;
        int stop_at;
        drained = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // path only: extreme byte values, '%' and '+' pass raw, end marker on the final byte
        put_char(8'h00);
        put_char(CH_PERCENT);
        put_char(CH_PLUS);
        put_char(8'hFF);
        send_url();
        // lower case escape, bad escape, '=' and '?' inside a value,
        // escape cut short by '&', trailing '&' gives no pair
        queue_text("?%4f%G==?%4&");
        send_url();
        // '+' as space, pair without '=', empty segment, upper case escape,
        // escape pending at the end of the url
        queue_text("?+&&%A1%6");
        send_url();

        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if (!drained && bytes_sent > stop_at - RANDOM_BYTES / 2) begin
                drain_results();
                drained = 1'b1;
            end
            if (bytes_sent >= stop_at - CALM_BYTES) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                // some urls run with no idling at all
                gaps_on   = $urandom_range(0, 9) < 7;
                stalls_on = $urandom_range(0, 9) < 7;
            end
            build_url();
            send_url();
        end

        s_tvalid  <= 1'b0;
        stalls_on = 1'b0;
        @(posedge aclk);
        while (board.busy()) @(posedge aclk);
        // catch any stray result behind the last expected one
        repeat (SETTLE) @(posedge aclk);

        if (board.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
